// ===== hw/rtl/lazy_range_add_range_sum_tree_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the range add / range sum unit
// Shared clocking and reset qualification for concurrent checks.
// ----------------------------------------------------------------------------
`ifndef LAZY_RANGE_ADD_RANGE_SUM_TREE_UNIT_ASSERT_SVH
`define LAZY_RANGE_ADD_RANGE_SUM_TREE_UNIT_ASSERT_SVH

// check an implication in the same cycle
`define LRAST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// check an implication in the next cycle
`define LRAST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/lrast_pkg.sv =====
// ----------------------------------------------------------------------------
// lrast_pkg
// Types and constants shared by the range add / range sum unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lrast_pkg;

    localparam int LEAVES_DEF = 1024;
    localparam int SIZE_W     = 11;
    localparam int DELTA_W    = 32;
    localparam int SUM_W      = 64;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                      operation;
        logic [SIZE_W-1:0]         range_low;
        logic [SIZE_W-1:0]         range_high;
        logic signed [DELTA_W-1:0] delta;
    } in_word_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] range_sum;
        logic                    range_error;
    } out_word_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lrast_ram.sv =====
// ----------------------------------------------------------------------------
// lrast_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lrast_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lazy_range_add_range_sum_tree_unit.sv =====
// ----------------------------------------------------------------------------
// lazy_range_add_range_sum_tree_unit
// Range add / range sum over LEAVES signed 64-bit positions.
// ----------------------------------------------------------------------------
// The unit keeps positions 1..active_size, all zero after reset, and takes
// one word at a time: an add of a signed delta over an inclusive range (no
// result) or a query of the wrapped 64-bit sum over a range (one result
// word). A range with low = 0, high < low, or high above the clamped size is
// dropped; a query on it returns sum 0 with range_error set. The state sits
// in two single-port RAMs of LEAVES words that hold the two coefficient
// arrays of a binary indexed tree: an add is two point updates, a query two
// prefix sums, each prefix weighted by its index. Every tree step is a read
// followed by a write or an accumulate, and a walk touches at most
// log2(LEAVES)+1 entries. A query may also wait for the output register; a
// rejected add returns to idle with no result, and a rejected query goes
// straight to its result word. After reset and after every active_size
// write the RAMs are swept to zero, one entry per cycle, with in_ready low;
// a pending size write also holds in_ready low. A finished result waits in
// an output register, and the next word is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module lazy_range_add_range_sum_tree_unit #(
    parameter int LEAVES = lrast_pkg::LEAVES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire lrast_pkg::in_word_t             in_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output lrast_pkg::out_word_t                 out_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [lrast_pkg::SIZE_W-1:0]    cfg_data
);

    `include "lazy_range_add_range_sum_tree_unit_assert.svh"

    // index width holds up to 2*LEAVES, address width covers LEAVES entries
    localparam int IW = $clog2(LEAVES + 1) + 1;
    localparam int AW = $clog2(LEAVES);
    localparam int SW = lrast_pkg::SUM_W;

    localparam logic [IW-1:0] LEAF_MAX = IW'(LEAVES);
    localparam logic [AW-1:0] ADDR_MAX = AW'(LEAVES - 1);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_MUL   = 8'b0000_0100,
        S_RD    = 8'b0000_1000,
        S_WR    = 8'b0001_0000,
        S_PMUL  = 8'b0010_0000,
        S_PFIN  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t                         state_reg, state_next;
    logic [lrast_pkg::SIZE_W-1:0]   size_reg, size_next;
    logic [AW-1:0]                  clr_reg, clr_next;
    logic                           op_reg, op_next;
    logic                           pass_reg, pass_next;
    logic [IW-1:0]                  lo_reg, lo_next;
    logic [IW-1:0]                  hi_reg, hi_next;
    logic [IW-1:0]                  idx_reg, idx_next;
    logic [SW-1:0]                  d_reg, d_next;
    logic [SW-1:0]                  acc1_reg, acc1_next;
    logic [SW-1:0]                  acc2_reg, acc2_next;
    logic [SW-1:0]                  part_reg, part_next;
    logic                           err_reg, err_next;
    logic [SW-1:0]                  prod_reg, prod_next;
    logic                           out_valid_reg, out_valid_next;
    lrast_pkg::out_word_t           out_data_reg, out_data_next;

    logic [SW-1:0]  mul_a;
    logic [IW-1:0]  mul_b;
    logic [IW-1:0]  lowbit;
    logic [31:0]    eff_size;
    logic [31:0]    lo32;
    logic [31:0]    hi32;
    logic           bad_range;
    logic           mem_we;
    logic [AW-1:0]  mem_addr;
    logic [SW-1:0]  wdata1;
    logic [SW-1:0]  wdata2;
    logic [SW-1:0]  rdata1;
    logic [SW-1:0]  rdata2;
    logic [SW-1:0]  v1;
    logic [SW-1:0]  v2;
    logic [SW-1:0]  prefix;
    logic           in_bounds;

    // first coefficient array (per-position delta)
    lrast_ram #(.WIDTH(SW), .DEPTH(LEAVES)) u_coef_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (wdata1),
        .rdata (rdata1)
    );

    // second coefficient array (index-weighted correction)
    lrast_ram #(.WIDTH(SW), .DEPTH(LEAVES)) u_corr_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (wdata2),
        .rdata (rdata2)
    );

    // Range check against the clamped size.
    always_comb
    begin
        lo32 = 32'(in_data.range_low);
        hi32 = 32'(in_data.range_high);
        eff_size = 32'(size_reg);
        if (eff_size == 32'd0)
        begin
            eff_size = 32'd1;
        end
        else if (eff_size > 32'(LEAVES))
        begin
            eff_size = 32'(LEAVES);
        end
        bad_range = (lo32 == 32'd0) || (hi32 < lo32) || (hi32 > eff_size);
    end

    // Shared multiplier: delta times an index, or a prefix times its index.
    // Add pass 0 weights by low-1 and pass 1 by high; query is the reverse.
    assign mul_a     = (state_reg == S_PMUL) ? acc1_reg : d_reg;
    assign mul_b     = (pass_reg ^ op_reg) ? hi_reg : (lo_reg - IW'(1));
    assign prod_next = mul_a * {{(SW - IW){1'b0}}, mul_b};

    assign lowbit    = idx_reg & (~idx_reg + IW'(1));
    assign in_bounds = (idx_reg != '0) && (idx_reg <= LEAF_MAX);

    // Pass 0 adds +d at low, pass 1 adds -d at high+1.
    assign v1 = pass_reg ? (~d_reg + SW'(1)) : d_reg;
    assign v2 = pass_reg ? (~prod_reg + SW'(1)) : prod_reg;

    assign prefix = prod_reg - acc2_reg;

    assign mem_we   = (state_reg == S_CLEAR) || ((state_reg == S_WR) && (op_reg == lrast_pkg::OP_ADD));
    assign mem_addr = (state_reg == S_CLEAR) ? clr_reg : AW'(idx_reg - IW'(1));
    assign wdata1   = (state_reg == S_CLEAR) ? '0 : (rdata1 + v1);
    assign wdata2   = (state_reg == S_CLEAR) ? '0 : (rdata2 + v2);

    // a pending size write goes first; hold the word until the sweep ends
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE) || (state_reg == S_CLEAR);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        size_next      = size_reg;
        clr_next       = clr_reg;
        op_next        = op_reg;
        pass_next      = pass_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        idx_next       = idx_reg;
        d_next         = d_reg;
        acc1_next      = acc1_reg;
        acc2_next      = acc2_reg;
        part_next      = part_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        // drop the result word once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == ADDR_MAX)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    op_next   = in_data.operation;
                    lo_next   = IW'(in_data.range_low);
                    hi_next   = IW'(in_data.range_high);
                    d_next    = SW'(in_data.delta);
                    pass_next = 1'b0;
                    if (!bad_range)
                    begin
                        state_next = S_MUL;
                    end
                    else if (in_data.operation == lrast_pkg::OP_QUERY)
                    begin
                        part_next  = '0;
                        err_next   = 1'b1;
                        state_next = S_DONE;
                    end
                end
            end

            S_MUL:
            begin
                // set the walk start; the product settles meanwhile
                acc1_next  = '0;
                acc2_next  = '0;
                state_next = S_RD;
                if (op_reg == lrast_pkg::OP_ADD)
                begin
                    idx_next = pass_reg ? (hi_reg + IW'(1)) : lo_reg;
                end
                else
                begin
                    idx_next = pass_reg ? (lo_reg - IW'(1)) : hi_reg;
                end
            end

            S_RD:
            begin
                if (op_reg == lrast_pkg::OP_ADD)
                begin
                    if (in_bounds)
                    begin
                        state_next = S_WR;
                    end
                    else if (pass_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        pass_next  = 1'b1;
                        state_next = S_MUL;
                    end
                end
                else
                begin
                    state_next = (idx_reg != '0) ? S_WR : S_PMUL;
                end
            end

            S_WR:
            begin
                state_next = S_RD;
                if (op_reg == lrast_pkg::OP_ADD)
                begin
                    idx_next = idx_reg + lowbit;
                end
                else
                begin
                    acc1_next = acc1_reg + rdata1;
                    acc2_next = acc2_reg + rdata2;
                    idx_next  = idx_reg - lowbit;
                end
            end

            S_PMUL:
            begin
                state_next = S_PFIN;
            end

            S_PFIN:
            begin
                if (!pass_reg)
                begin
                    part_next  = prefix;
                    pass_next  = 1'b1;
                    state_next = S_MUL;
                end
                else
                begin
                    part_next  = part_reg - prefix;
                    err_next   = 1'b0;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.range_sum = part_reg;
                    out_data_next.range_error = err_reg;
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_CLEAR;
                clr_next   = '0;
            end
        endcase

        // a size write restarts the sweep
        if (cfg_valid && cfg_ready)
        begin
            size_next  = cfg_data;
            clr_next   = '0;
            state_next = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            size_reg      <= lrast_pkg::SIZE_RESET;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        pass_reg     <= pass_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        idx_reg      <= idx_next;
        d_reg        <= d_next;
        acc1_reg     <= acc1_next;
        acc2_reg     <= acc2_next;
        part_reg     <= part_next;
        err_reg      <= err_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    `LRAST_ASSERT_NEXT(a_cfg_clears, cfg_valid && cfg_ready, state_reg == S_CLEAR, "size write did not start sweep")
    `LRAST_ASSERT_NOW(a_add_bounds, (state_reg == S_WR) && (op_reg == lrast_pkg::OP_ADD), (idx_reg != '0) && (idx_reg <= LEAF_MAX), "update outside tree")
    `LRAST_ASSERT_NOW(a_err_zero, out_valid && out_data.range_error, out_data.range_sum == '0, "rejected query with nonzero sum")

endmodule

`default_nettype wire
